/* hw/rtl/sts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere triangle subdivider package
// Shared constants, beat types and the control state enum.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int MAX_DEPTH_DEF  = 3;
   localparam int COORD_BITS_DEF = 16;
   localparam int CW             = COORD_BITS_DEF;
   localparam int DEPTH_W        = 2;

   typedef struct packed {
      logic signed [CW-1:0] vert_a_x;
      logic signed [CW-1:0] vert_a_y;
      logic signed [CW-1:0] vert_a_z;
      logic signed [CW-1:0] vert_b_x;
      logic signed [CW-1:0] vert_b_y;
      logic signed [CW-1:0] vert_b_z;
      logic signed [CW-1:0] vert_c_x;
      logic signed [CW-1:0] vert_c_y;
      logic signed [CW-1:0] vert_c_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] out_a_x;
      logic signed [CW-1:0] out_a_y;
      logic signed [CW-1:0] out_a_z;
      logic signed [CW-1:0] out_b_x;
      logic signed [CW-1:0] out_b_y;
      logic signed [CW-1:0] out_b_z;
      logic signed [CW-1:0] out_c_x;
      logic signed [CW-1:0] out_c_y;
      logic signed [CW-1:0] out_c_z;
      logic                 last_triangle;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RD,
      ST_RDW,
      ST_SUM,
      ST_SQRT,
      ST_DIV,
      ST_WR,
      ST_ORD,
      ST_ORDW,
      ST_EMIT,
      ST_POP
   } state_type;

endpackage
`default_nettype wire

/* hw/rtl/sphere_triangle_subdivider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere triangle subdivider
// Depth-first subdivision of a unit-sphere triangle into 4^depth leaves.
// ----------------------------------------------------------------------------
// One triangle is taken at a time and produces 4^depth leaf triangles, the
// last one flagged. Each level keeps its triangle in a vertex memory written
// one coordinate per cycle and read one coordinate at a time. Every child
// costs three projections, each one square root and three divisions on a
// shared divider unit. Emitting a leaf reads nine words and waits while the
// previous beat is held.
module sphere_triangle_subdivider #(
   parameter int MAX_DEPTH = sts_pkg::MAX_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire sts_pkg::req_type         req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output sts_pkg::rsp_type              rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [sts_pkg::DEPTH_W-1:0] csr_data
);
   import sts_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEF;
   localparam int FB    = COORD_BITS - 2;
   localparam int LEV   = MAX_DEPTH + 1;
   localparam int WORDS = LEV * 9;
   localparam int AW    = $clog2(WORDS);
   localparam int SW    = COORD_BITS + 1;
   localparam int QW    = 2 * SW + 2;
   localparam int RW    = QW / 2;
   localparam int NW    = SW + FB;
   localparam int LW    = $clog2(LEV);

   state_type state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff;
   logic [LW-1:0]      lvl_ff, lvl_in;
   logic [1:0]         kidx_ff [LEV];
   logic [3:0]         cnt_ff, cnt_in;
   logic [1:0]         proj_ff, proj_in;
   logic [1:0]         comp_ff, comp_in;
   logic               pass_ff, pass_in;
   logic [LW-1:0]      eff_depth;

   logic signed [COORD_BITS-1:0] tri_ff [9];
   logic signed [COORD_BITS-1:0] mid_ff [9];
   logic signed [SW-1:0]         sum_ff [3];
   logic [QW-1:0]                q_sum;
   logic [RW-1:0]                d_ff;
   rsp_type                      out_ff;
   logic                         out_v_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [COORD_BITS-1:0] wr_data, rd_data;
   logic                  sq_start, sq_done, dv_start, dv_done;
   logic [RW-1:0]         sq_root;
   logic [RW-1:0]         dv_den;
   logic [NW-1:0]         dv_quo;
   logic [NW-1:0]         dv_num;
   logic signed [SW-1:0]  cur_s;
   logic [SW-1:0]         mag;
   logic signed [NW:0]    qsig;
   logic signed [COORD_BITS-1:0] coord_res;
   logic                  last_leaf;
   logic [4:0]            sel_idx;
   logic [3:0]            rd_idx;

   localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1) << FB;

   function automatic logic signed [COORD_BITS-1:0] sat_in(logic [CW-1:0] v);
      logic signed [COORD_BITS-1:0] t;
      t = COORD_BITS'(v);
      if (t > ONE) return ONE;
      if (t < -ONE) return -ONE;
      return t;
   endfunction

   assign eff_depth = (int'(depth_ff) > MAX_DEPTH) ? LW'(MAX_DEPTH) : LW'(depth_ff);

   sts_ram #(.WIDTH(COORD_BITS), .DEPTH(WORDS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   sts_sqrt #(.QW(QW)) u_sqrt (
      .clock, .reset, .start(sq_start), .q(q_sum), .done(sq_done), .root(sq_root)
   );

   sts_div #(.NW(NW), .DW(RW)) u_div (
      .clock, .reset, .start(dv_start), .num(dv_num), .den(dv_den),
      .done(dv_done), .quo(dv_quo)
   );

   // Pairs per projection: (a,b), (a,c), (c,b); vertex index base 0,3,6.
   function automatic logic [3:0] pair_p(logic [1:0] p);
      return (p == 2'd2) ? 4'd6 : 4'd0;
   endfunction
   function automatic logic [3:0] pair_q(logic [1:0] p);
      return (p == 2'd1) ? 4'd6 : 4'd3;
   endfunction

   assign q_sum = QW'(sum_ff[0] * sum_ff[0]) + QW'(sum_ff[1] * sum_ff[1])
                + QW'(sum_ff[2] * sum_ff[2]);
   assign dv_den = (state_ff == ST_SQRT) ? sq_root : d_ff;

   assign cur_s = sum_ff[comp_ff];
   assign mag   = cur_s[SW-1] ? SW'(-cur_s) : SW'(cur_s);
   assign dv_num = NW'(mag) << FB;
   always_comb begin
      logic signed [NW:0] v;
      v = cur_s[SW-1] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
      qsig = v;
      if (d_ff == '0) begin
         qsig = (NW+1)'(cur_s);
      end
      if (qsig > (NW+1)'(ONE)) coord_res = ONE;
      else if (qsig < -(NW+1)'(ONE)) coord_res = -ONE;
      else coord_res = COORD_BITS'(qsig);
   end

   // Child selection: word j of child k at the next level.
   always_comb begin
      logic [1:0] vtx;
      logic [1:0] k;
      logic [3:0] off;
      k = kidx_ff[lvl_ff];
      if (cnt_ff < 4'd3) begin
         vtx = 2'd0;
         off = cnt_ff;
      end else if (cnt_ff < 4'd6) begin
         vtx = 2'd1;
         off = cnt_ff - 4'd3;
      end else begin
         vtx = 2'd2;
         off = cnt_ff - 4'd6;
      end
      unique case (k)
         2'd0: sel_idx = (vtx == 2'd0) ? 5'd0 : (vtx == 2'd1) ? 5'd9 : 5'd12;
         2'd1: sel_idx = (vtx == 2'd0) ? 5'd6 : (vtx == 2'd1) ? 5'd12 : 5'd15;
         2'd2: sel_idx = (vtx == 2'd0) ? 5'd3 : (vtx == 2'd1) ? 5'd15 : 5'd9;
         default: sel_idx = (vtx == 2'd0) ? 5'd9 : (vtx == 2'd1) ? 5'd12 : 5'd15;
      endcase
      sel_idx = sel_idx + 5'(off);
   end

   always_comb begin
      last_leaf = 1'b1;
      for (int i = 0; i < LEV; i++) begin
         if (i < int'(eff_depth) && kidx_ff[i] != 2'd3) last_leaf = 1'b0;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_idx  = cnt_ff;
      rd_addr = AW'(int'(lvl_ff) * 9 + int'(cnt_ff));
      sq_start = (state_ff == ST_SUM) && pass_ff;
      dv_start = 1'b0;
      unique case (state_ff)
         ST_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'((int'(lvl_ff) + 1) * 9 + int'(cnt_ff));
            wr_data = (sel_idx < 5'd9) ? tri_ff[4'(sel_idx)] : mid_ff[4'(sel_idx - 5'd9)];
         end
         ST_LOAD: begin
            wr_en   = 1'b1;
            wr_addr = AW'(cnt_ff);
            unique case (cnt_ff)
               4'd0: wr_data = sat_in(req_data.vert_a_x);
               4'd1: wr_data = sat_in(req_data.vert_a_y);
               4'd2: wr_data = sat_in(req_data.vert_a_z);
               4'd3: wr_data = sat_in(req_data.vert_b_x);
               4'd4: wr_data = sat_in(req_data.vert_b_y);
               4'd5: wr_data = sat_in(req_data.vert_b_z);
               4'd6: wr_data = sat_in(req_data.vert_c_x);
               4'd7: wr_data = sat_in(req_data.vert_c_y);
               default: wr_data = sat_in(req_data.vert_c_z);
            endcase
         end
         ST_SQRT: dv_start = sq_done;
         ST_DIV:  dv_start = pass_ff;
         default: ;
      endcase
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      cnt_in   = cnt_ff;
      proj_in  = proj_ff;
      comp_in  = comp_ff;
      pass_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = ST_LOAD;
            cnt_in   = '0;
         end
         ST_LOAD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd8) begin
               lvl_in   = '0;
               cnt_in   = '0;
               state_in = (eff_depth == '0) ? ST_ORD : ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_RDW;
         end
         ST_RDW: begin
            cnt_in = cnt_ff + 1'b1;
            state_in = ST_RD;
            if (cnt_ff == 4'd8) begin
               cnt_in   = '0;
               proj_in  = '0;
               state_in = ST_SUM;
               pass_in  = 1'b0;
            end
         end
         ST_SUM: begin
            if (!pass_ff) begin
               pass_in = 1'b1;
            end else begin
               state_in = ST_SQRT;
               comp_in  = '0;
            end
         end
         ST_SQRT: if (sq_done) state_in = ST_DIV;
         ST_DIV: if (dv_done) begin
            comp_in = comp_ff + 1'b1;
            pass_in = 1'b1;
            if (comp_ff == 2'd2) begin
               pass_in = 1'b0;
               comp_in = '0;
               if (proj_ff == 2'd2) begin
                  state_in = ST_WR;
                  cnt_in   = '0;
               end else begin
                  proj_in  = proj_ff + 1'b1;
                  state_in = ST_SUM;
               end
            end
         end
         ST_WR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd8) begin
               cnt_in = '0;
               lvl_in = lvl_ff + 1'b1;
               state_in = (lvl_ff + 1'b1 == eff_depth) ? ST_ORD : ST_RD;
            end
         end
         ST_ORD: state_in = ST_ORDW;
         ST_ORDW: begin
            cnt_in = cnt_ff + 1'b1;
            state_in = ST_ORD;
            if (cnt_ff == 4'd8) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: if (!out_v_ff || !rsp_stall) state_in = ST_POP;
         ST_POP: begin
            if (last_leaf) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RD;
               for (int i = LEV - 1; i >= 0; i--) begin
                  if (i < int'(eff_depth) && kidx_ff[i] != 2'd3) begin
                     if (LW'(i) < lvl_in || i == int'(eff_depth) - 1) lvl_in = LW'(i);
                  end
               end
               for (int i = 0; i < LEV; i++) begin
                  if (i < int'(eff_depth) && kidx_ff[i] != 2'd3) lvl_in = LW'(i);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         depth_ff <= DEPTH_W'(3);
         lvl_ff   <= '0;
         cnt_ff   <= '0;
         proj_ff  <= '0;
         comp_ff  <= '0;
         pass_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < LEV; i++) kidx_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         cnt_ff   <= cnt_in;
         proj_ff  <= proj_in;
         comp_ff  <= comp_in;
         pass_ff  <= pass_in;
         if (csr_valid && csr_ready) depth_ff <= csr_data;
         if (state_ff == ST_EMIT && (!out_v_ff || !rsp_stall)) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
         if (state_ff == ST_IDLE) begin
            for (int i = 0; i < LEV; i++) kidx_ff[i] <= '0;
         end
         if (state_ff == ST_POP) begin
            for (int i = 0; i < LEV; i++) begin
               if (LW'(i) > lvl_in) kidx_ff[i] <= '0;
               else if (LW'(i) == lvl_in && !last_leaf) kidx_ff[i] <= kidx_ff[i] + 1'b1;
            end
         end
      end
      if (state_ff == ST_RDW || state_ff == ST_ORDW) tri_ff[rd_idx] <= rd_data;
      if (state_ff == ST_SUM && !pass_ff) begin
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= SW'(tri_ff[pair_p(proj_ff) + 4'(i)])
                       + SW'(tri_ff[pair_q(proj_ff) + 4'(i)]);
         end
      end
      if (state_ff == ST_SQRT && sq_done) d_ff <= sq_root;
      if (state_ff == ST_DIV && dv_done) mid_ff[int'(proj_ff) * 3 + int'(comp_ff)] <= coord_res;
      if (state_ff == ST_EMIT && (!out_v_ff || !rsp_stall)) begin
         out_ff.out_a_x <= CW'(tri_ff[0]);
         out_ff.out_a_y <= CW'(tri_ff[1]);
         out_ff.out_a_z <= CW'(tri_ff[2]);
         out_ff.out_b_x <= CW'(tri_ff[3]);
         out_ff.out_b_y <= CW'(tri_ff[4]);
         out_ff.out_b_z <= CW'(tri_ff[5]);
         out_ff.out_c_x <= CW'(tri_ff[6]);
         out_ff.out_c_y <= CW'(tri_ff[7]);
         out_ff.out_c_z <= CW'(tri_ff[8]);
         out_ff.last_triangle <= last_leaf;
      end
   end

   assign req_stall = !(state_ff == ST_LOAD && cnt_ff == 4'd8);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign csr_ready = (state_ff == ST_IDLE);

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> req_stall)
      else $error("input taken outside load");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> (state_ff == ST_IDLE))
      else $error("config open while busy");
   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> (lvl_ff < eff_depth))
      else $error("child write beyond depth");
endmodule
`default_nettype wire

/* hw/rtl/sts_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 36
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/sts_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative integer square root
// Produces floor(sqrt(q)) one result bit per cycle.
// ----------------------------------------------------------------------------
module sts_sqrt #(
   parameter int QW = 36
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [QW-1:0]   q,
   output logic                 done,
   output logic [QW/2-1:0]      root
);
   localparam int RW = QW / 2;
   localparam int CNTW = $clog2(RW + 1);

   logic [QW-1:0]   rem_ff, rem_in;
   logic [QW-1:0]   src_ff, src_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [QW+1:0]   trial;
   logic [QW+1:0]   shifted;

   always_comb begin
      rem_in  = rem_ff;
      src_in  = src_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff, src_ff[QW-1:QW-2]};
      trial   = (QW+2)'({root_ff, 2'b01});
      if (start) begin
         rem_in  = '0;
         src_in  = q;
         root_in = '0;
         cnt_in  = CNTW'(RW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         src_in = {src_ff[QW-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = QW'(shifted - trial);
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = QW'(shifted);
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      root_ff <= root_in;
   end

   assign done = busy_ff && (cnt_ff == CNTW'(1));
   assign root = root_in;
endmodule
`default_nettype wire

/* hw/rtl/sts_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sts_div #(
   parameter int NW = 32,
   parameter int DW = 18
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quo
);
   localparam int CNTW = $clog2(NW + 1);

   logic [DW:0]     rem_ff, rem_in;
   logic [NW-1:0]   q_ff, q_in;
   logic [DW-1:0]   d_ff, d_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [DW+1:0]   sh;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sh      = {rem_ff, q_ff[NW-1]};
      if (start) begin
         rem_in  = '0;
         q_in    = num;
         d_in    = den;
         cnt_in  = CNTW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {2'b00, d_ff}) begin
            rem_in = (DW+1)'(sh - {2'b00, d_ff});
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = (DW+1)'(sh);
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign done = busy_ff && (cnt_ff == CNTW'(1));
   assign quo  = q_in;
endmodule
`default_nettype wire
